@@ hdl/lsps_pkg.sv @@
// ---------------------------------------------------------------------------
// Lattice site particle store package
// Shared widths, codes, reset values and inter-module structs.
// ---------------------------------------------------------------------------
package lsps_pkg;

   // default sizing of the stores
   localparam int MAX_SITES_DEF = 4096;
   localparam int MAX_WORDS_DEF = 4;

   // field widths
   localparam int CFG_W      = 13;
   localparam int WORDS_W    = 3;
   localparam int COORD_W    = 12;
   localparam int SITE_IDX_W = 13;
   localparam int CMD_W      = 3;
   localparam int SLOT_W     = 4;
   localparam int VAL_W      = 8;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 16;
   localparam int WORD_W     = 32;

   // commands
   localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_OCC      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SET_TYPE = 3'd4;
   localparam logic [CMD_W-1:0] CMD_GET_TYPE = 3'd5;

   // result status
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SITE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SITE_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WORDS      = 3'd4;

   // register reset values
   localparam logic [CFG_W-1:0]   SIZE_RST  = 13'd16;
   localparam logic [CFG_W-1:0]   SITES_RST = 13'd4096;
   localparam logic [WORDS_W-1:0] WORDS_RST = 3'd1;

   // request into the site resolver
   typedef struct packed {
      logic               start;
      logic               flat;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [COORD_W-1:0] index;
   } site_req_type;

   // answer from the site resolver
   typedef struct packed {
      logic                  done;
      logic                  ok;
      logic [SITE_IDX_W-1:0] site;
   } site_res_type;

endpackage

@@ hdl/lsps_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module lsps_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/lsps_resolve.sv @@
// ---------------------------------------------------------------------------
// Site resolver
// Three-stage pipeline: coordinates or flat index to a checked site index.
// ---------------------------------------------------------------------------
module lsps_resolve (
   input  logic                              clock,
   input  logic                              reset,
   input  lsps_pkg::site_req_type            req,
   input  logic [lsps_pkg::CFG_W-1:0]        size_x,
   input  logic [lsps_pkg::CFG_W-1:0]        size_y,
   input  logic [lsps_pkg::CFG_W-1:0]        size_z,
   input  logic [lsps_pkg::CFG_W-1:0]        eff_sites,
   output lsps_pkg::site_res_type            res
);

   // stage 1: range checks, y*sx and sx*sy
   logic                             v1_ff;
   logic                             flat1_ff;
   logic                             inrange1_ff;
   logic [lsps_pkg::COORD_W-1:0]     x1_ff;
   logic [lsps_pkg::COORD_W-1:0]     z1_ff;
   logic [lsps_pkg::COORD_W-1:0]     idx1_ff;
   logic [24:0]                      yx1_ff;
   logic [25:0]                      sxy1_ff;

   // stage 2: x + y*sx and z*sx*sy
   logic                             v2_ff;
   logic                             flat2_ff;
   logic                             inrange2_ff;
   logic [lsps_pkg::COORD_W-1:0]     idx2_ff;
   logic [25:0]                      xy2_ff;
   logic [37:0]                      zp2_ff;

   // stage 3: final sum and bound check
   logic [38:0]                      sum_w;
   logic                             done3_ff;
   logic                             ok3_ff;
   logic [lsps_pkg::SITE_IDX_W-1:0]  site3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         done3_ff <= 1'b0;
      end else begin
         v1_ff    <= req.start;
         v2_ff    <= v1_ff;
         done3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      flat1_ff    <= req.flat;
      inrange1_ff <= ({1'b0, req.x} < size_x) && ({1'b0, req.y} < size_y) &&
                     ({1'b0, req.z} < size_z);
      x1_ff       <= req.x;
      z1_ff       <= req.z;
      idx1_ff     <= req.index;
      yx1_ff      <= 25'(req.y) * 25'(size_x);
      sxy1_ff     <= 26'(size_x) * 26'(size_y);

      flat2_ff    <= flat1_ff;
      inrange2_ff <= inrange1_ff;
      idx2_ff     <= idx1_ff;
      xy2_ff      <= 26'(x1_ff) + 26'(yx1_ff);
      zp2_ff      <= 38'(z1_ff) * 38'(sxy1_ff);

      if (flat2_ff) begin
         ok3_ff   <= {1'b0, idx2_ff} < eff_sites;
         site3_ff <= {1'b0, idx2_ff};
      end else begin
         ok3_ff   <= inrange2_ff && (sum_w < 39'(eff_sites));
         site3_ff <= sum_w[lsps_pkg::SITE_IDX_W-1:0];
      end
   end

   assign sum_w = 39'(xy2_ff) + 39'(zp2_ff);
   assign res   = '{done: done3_ff, ok: ok3_ff, site: site3_ff};

endmodule

@@ hdl/lattice_site_particle_store.sv @@
// ---------------------------------------------------------------------------
// Lattice site particle store
// Particle slots and site types of a 3-D lattice, held in two RAMs.
// ---------------------------------------------------------------------------
// Usage:
//  - req_ carries one command per transaction (add, read slot, occupancy,
//    clear site, set type, get type); tuser selects flat-index addressing.
//  - rsp_ returns exactly one result transaction per command: status, data
//    and occupancy, in command order.
//  - csr_ writes the lattice extents, site count and words per site; write
//    only while no command is in flight.
//  - One command at a time: req_tready is high only in the idle state. A
//    command passes the three-stage site resolver, then dispatch; a bad
//    site or unknown command goes straight to the result. Read slot, add
//    and occupancy read the particle RAM (one read port) and evaluate each
//    word before the next read; clear writes the words of the site; set
//    type and get type use the type RAM.
//  - After reset both RAMs are swept to zero, one particle word (and one
//    site type) per cycle over MAX_SITES*MAX_WORDS words, req_tready low.
//  - The result sits in an output register; a stalled receiver holds it
//    there, a new command is still accepted and its result waits in the
//    last state until the register frees.
// ---------------------------------------------------------------------------
module lattice_site_particle_store #(
   parameter int MAX_SITES = lsps_pkg::MAX_SITES_DEF,
   parameter int MAX_WORDS = lsps_pkg::MAX_WORDS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: command[2:0], coord_x[14:3], coord_y[26:15], coord_z[38:27],
   //        site_index[50:39], slot[54:51], value[62:55], zero[63]
   input  logic [lsps_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: use_flat_index
   input  logic                                req_tuser,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: status[1:0], data[9:2], occupancy[14:10], zero[15]
   output logic [lsps_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // register writes
   input  logic                                csr_we,
   input  logic [lsps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lsps_pkg::CFG_W-1:0]          csr_wdata
);

   localparam int DEPTH  = MAX_SITES * MAX_WORDS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SITE_W = $clog2(MAX_SITES);

   // controller states
   localparam logic [3:0] S_INIT     = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_RESOLVE  = 4'd2;
   localparam logic [3:0] S_DISPATCH = 4'd3;
   localparam logic [3:0] S_RD       = 4'd4;
   localparam logic [3:0] S_EVAL     = 4'd5;
   localparam logic [3:0] S_CLR      = 4'd6;
   localparam logic [3:0] S_TEVAL    = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   // configuration
   logic [lsps_pkg::CFG_W-1:0]   size_x_ff, size_y_ff, size_z_ff, site_count_ff;
   logic [lsps_pkg::WORDS_W-1:0] words_ff;
   logic [lsps_pkg::CFG_W-1:0]   eff_sites_w;
   logic [lsps_pkg::WORDS_W-1:0] eff_words_w;

   // control and working registers
   logic [3:0]                      state_ff, state_in;
   logic [ADDR_W-1:0]               clr_ff, clr_in;
   logic [lsps_pkg::CMD_W-1:0]      cmd_ff, cmd_in;
   logic [lsps_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic [lsps_pkg::VAL_W-1:0]      val_ff, val_in;
   logic [lsps_pkg::SITE_IDX_W-1:0] site_ff, site_in;
   logic [ADDR_W-1:0]               addr_ff, addr_in;
   logic [lsps_pkg::WORDS_W-1:0]    w_ff, w_in;
   logic [lsps_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [lsps_pkg::VAL_W-1:0]      data_ff, data_in;
   logic [lsps_pkg::OCC_W-1:0]      occ_ff, occ_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lsps_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // resolver
   lsps_pkg::site_req_type site_req;
   lsps_pkg::site_res_type site_res;

   // memories
   logic                            pw_we;
   logic [ADDR_W-1:0]               pw_waddr;
   logic [lsps_pkg::WORD_W-1:0]     pw_wdata, pw_rdata;
   logic                            tt_we;
   logic [SITE_W-1:0]               tt_waddr, tt_raddr;
   logic [lsps_pkg::VAL_W-1:0]      tt_wdata, tt_rdata;

   // word evaluation
   logic [3:0]                      zero_b;
   logic                            found_w;
   logic [1:0]                      fz_w;
   logic [2:0]                      lead_w;
   logic [lsps_pkg::WORD_W-1:0]     add_word_w;
   logic [lsps_pkg::VAL_W-1:0]      slot_byte_w;
   logic                            more_w;
   logic [lsps_pkg::WORDS_W-1:0]    w_next_w;
   logic                            slot_bad_w;
   logic [14:0]                     slot_off_w;
   logic [ADDR_W-1:0]               site_base_w, read_addr_w, addr_step_w;
   logic                            accept_w;

   // saturate against the store sizes
   assign eff_sites_w = (32'(site_count_ff) > MAX_SITES) ?
                        lsps_pkg::CFG_W'(MAX_SITES) : site_count_ff;
   assign eff_words_w = (32'(words_ff) > MAX_WORDS) ?
                        lsps_pkg::WORDS_W'(MAX_WORDS) : words_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff     <= lsps_pkg::SIZE_RST;
         size_y_ff     <= lsps_pkg::SIZE_RST;
         size_z_ff     <= lsps_pkg::SIZE_RST;
         site_count_ff <= lsps_pkg::SITES_RST;
         words_ff      <= lsps_pkg::WORDS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            lsps_pkg::CSR_SIZE_X:     size_x_ff     <= csr_wdata;
            lsps_pkg::CSR_SIZE_Y:     size_y_ff     <= csr_wdata;
            lsps_pkg::CSR_SIZE_Z:     size_z_ff     <= csr_wdata;
            lsps_pkg::CSR_SITE_COUNT: site_count_ff <= csr_wdata;
            lsps_pkg::CSR_WORDS:      words_ff      <= csr_wdata[lsps_pkg::WORDS_W-1:0];
            default: ;
         endcase
      end
   end

   assign accept_w   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   assign site_req.start = accept_w;
   assign site_req.flat  = req_tuser;
   assign site_req.x     = req_tdata[14:3];
   assign site_req.y     = req_tdata[26:15];
   assign site_req.z     = req_tdata[38:27];
   assign site_req.index = req_tdata[50:39];

   lsps_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .req       (site_req),
      .size_x    (size_x_ff),
      .size_y    (size_y_ff),
      .size_z    (size_z_ff),
      .eff_sites (eff_sites_w),
      .res       (site_res)
   );

   // word w of a site sits at site + w*eff_sites
   assign site_base_w = ADDR_W'(32'(site_ff));
   assign addr_step_w = ADDR_W'(32'(eff_sites_w));
   assign slot_off_w  = 15'(slot_ff[3:2]) * 15'(eff_sites_w);
   assign read_addr_w = ADDR_W'(32'(site_ff) + 32'(slot_off_w));
   assign slot_bad_w  = {1'b0, slot_ff} >= {eff_words_w, 2'b00};
   assign w_next_w    = w_ff + 3'd1;
   assign more_w      = w_next_w < eff_words_w;
   assign tt_raddr    = SITE_W'(32'(site_ff));

   // first empty byte of the word just read
   always_comb begin
      for (int b = 0; b < 4; b++) begin
         zero_b[b] = (pw_rdata[8*b +: 8] == 8'd0);
      end
      found_w = |zero_b;
      fz_w    = 2'd0;
      for (int b = 3; b >= 0; b--) begin
         if (zero_b[b]) begin
            fz_w = 2'(b);
         end
      end
      lead_w     = found_w ? {1'b0, fz_w} : 3'd4;
      add_word_w = pw_rdata;
      add_word_w[{fz_w, 3'b000} +: 8] = val_ff;
   end

   assign slot_byte_w = pw_rdata[{slot_ff[1:0], 3'b000} +: 8];

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      val_in       = val_ff;
      site_in      = site_ff;
      addr_in      = addr_ff;
      w_in         = w_ff;
      status_in    = status_ff;
      data_in      = data_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pw_we        = 1'b0;
      pw_waddr     = addr_ff;
      pw_wdata     = add_word_w;
      tt_we        = 1'b0;
      tt_waddr     = tt_raddr;
      tt_wdata     = val_ff;

      unique case (state_ff)
         S_INIT: begin
            // zero sweep over both RAMs
            pw_we    = 1'b1;
            pw_waddr = clr_ff;
            pw_wdata = '0;
            tt_we    = 32'(clr_ff) < MAX_SITES;
            tt_waddr = SITE_W'(clr_ff);
            tt_wdata = '0;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept_w) begin
               cmd_in    = req_tdata[2:0];
               slot_in   = req_tdata[54:51];
               val_in    = req_tdata[62:55];
               status_in = lsps_pkg::ST_OK;
               data_in   = '0;
               occ_in    = '0;
               w_in      = '0;
               state_in  = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            if (site_res.done) begin
               site_in = site_res.site;
               if (cmd_ff > lsps_pkg::CMD_GET_TYPE) begin
                  state_in = S_DONE;
               end else if (!site_res.ok) begin
                  status_in = lsps_pkg::ST_BAD_SITE;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_DISPATCH;
               end
            end
         end
         S_DISPATCH: begin
            addr_in = site_base_w;
            unique case (cmd_ff)
               lsps_pkg::CMD_ADD: begin
                  if (eff_words_w == '0) begin
                     status_in = lsps_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_RD;
                  end
               end
               lsps_pkg::CMD_OCC: begin
                  state_in = (eff_words_w == '0) ? S_DONE : S_RD;
               end
               lsps_pkg::CMD_READ: begin
                  if (slot_bad_w) begin
                     status_in = lsps_pkg::ST_BAD_SLOT;
                     state_in  = S_DONE;
                  end else begin
                     addr_in  = read_addr_w;
                     state_in = S_RD;
                  end
               end
               lsps_pkg::CMD_CLEAR: begin
                  state_in = (eff_words_w == '0) ? S_DONE : S_CLR;
               end
               lsps_pkg::CMD_SET_TYPE: begin
                  tt_we    = 1'b1;
                  state_in = S_DONE;
               end
               default: begin
                  // get type: type RAM read issued this cycle
                  state_in = S_TEVAL;
               end
            endcase
         end
         S_RD: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            unique case (cmd_ff)
               lsps_pkg::CMD_READ: begin
                  data_in  = slot_byte_w;
                  state_in = S_DONE;
               end
               lsps_pkg::CMD_ADD: begin
                  if (found_w) begin
                     pw_we    = 1'b1;
                     state_in = S_DONE;
                  end else if (more_w) begin
                     w_in     = w_next_w;
                     addr_in  = addr_ff + addr_step_w;
                     state_in = S_RD;
                  end else begin
                     status_in = lsps_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end
               end
               default: begin
                  // occupancy: stop at the first empty slot
                  occ_in = occ_ff + 5'(lead_w);
                  if (found_w || !more_w) begin
                     state_in = S_DONE;
                  end else begin
                     w_in     = w_next_w;
                     addr_in  = addr_ff + addr_step_w;
                     state_in = S_RD;
                  end
               end
            endcase
         end
         S_CLR: begin
            pw_we    = 1'b1;
            pw_wdata = '0;
            if (more_w) begin
               w_in    = w_next_w;
               addr_in = addr_ff + addr_step_w;
            end else begin
               state_in = S_DONE;
            end
         end
         S_TEVAL: begin
            data_in  = tt_rdata;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, occ_ff, data_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      slot_ff     <= slot_in;
      val_ff      <= val_in;
      site_ff     <= site_in;
      addr_ff     <= addr_in;
      w_ff        <= w_in;
      status_ff   <= status_in;
      data_ff     <= data_in;
      occ_ff      <= occ_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // particle words
   lsps_ram #(
      .WIDTH (lsps_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_words (
      .clock (clock),
      .we    (pw_we),
      .waddr (pw_waddr),
      .wdata (pw_wdata),
      .raddr (addr_ff),
      .rdata (pw_rdata)
   );

   // site types
   lsps_ram #(
      .WIDTH (lsps_pkg::VAL_W),
      .DEPTH (MAX_SITES)
   ) u_types (
      .clock (clock),
      .we    (tt_we),
      .waddr (tt_waddr),
      .wdata (tt_wdata),
      .raddr (tt_raddr),
      .rdata (tt_rdata)
   );

   // resolved site must lie inside the effective lattice
   a_site_in_range: assert property (@(posedge clock) disable iff (reset)
      site_res.done && site_res.ok |-> site_res.site < eff_sites_w)
      else $error("resolved site beyond site count");

   // word walk never passes the words in use
   a_word_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD || state_ff == S_CLR) |-> w_ff < eff_words_w)
      else $error("word index beyond words in use");

   // particle RAM written only by the sweep, an add or a clear
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      pw_we |-> (state_ff == S_INIT || state_ff == S_EVAL || state_ff == S_CLR))
      else $error("unexpected particle write");

   // a fresh result comes only out of the final state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside final state");

   // no command taken during the zero sweep
   a_init_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INIT |=> !$past(accept_w))
      else $error("command accepted during sweep");

endmodule
